FILE: sv/rfu_pkg.sv
package rfu_pkg;

   localparam int OPERAND_WIDTH = 32;
   localparam int DW = 2 * OPERAND_WIDTH;
   localparam int CW = $clog2(DW);

   typedef enum logic [1:0] {
      OP_NORMALIZE = 2'd0,
      OP_ADD       = 2'd1,
      OP_COMPARE   = 2'd2,
      OP_UNUSED    = 2'd3
   } op_type;

   typedef struct packed {
      logic [1:0]         command;
      logic signed [31:0] a_numerator;
      logic signed [31:0] a_denominator;
      logic signed [31:0] b_numerator;
      logic signed [31:0] b_denominator;
   } req_word_type;

   typedef struct packed {
      logic signed [63:0] result_numerator;
      logic [61:0]        result_denominator;
      logic               is_equal;
      logic               zero_denominator;
   } rsp_word_type;

   typedef struct packed {
      logic                     neg;
      logic [OPERAND_WIDTH-1:0] mag;
   } smag_type;

   typedef enum logic [4:0] {
      S_IDLE, S_CHECK, S_MUL1, S_MUL2, S_MUL3, S_SUM, S_CMP, S_NLOAD, S_ZTEST,
      S_GINIT, S_GTWO, S_GAEVEN, S_GLOOP, S_DIVN_INIT, S_DIVN, S_DIVD_INIT,
      S_DIVD, S_DIVD_DONE, S_TRIV, S_FINISH
   } state_type;

   typedef enum logic [4:0] {
      C_NONE, C_LOAD, C_TRIV, C_MUL1, C_MUL2, C_MUL3, C_SUM, C_CMP, C_NLOAD,
      C_GINIT, C_GTWO, C_GAEVEN, C_GSTEP, C_DIVN_INIT, C_DIV_STEP, C_DIVD_INIT,
      C_DIVD_DONE, C_OUT
   } dp_cmd_type;

   typedef struct packed {
      logic [1:0] command;
      logic       zerr;
      logic       num_zero;
      logic       both_even;
      logic       a_even;
      logic       b_zero;
      logic       div_last;
   } dp_status_type;

   function automatic smag_type split_operand(input logic [31:0] v);
      logic [OPERAND_WIDTH-1:0] x;
      smag_type r;
      x = v[OPERAND_WIDTH-1:0];
      r.neg = x[OPERAND_WIDTH-1];
      r.mag = r.neg ? (~x + 1'b1) : x;
      return r;
   endfunction

endpackage

FILE: sv/rfu_datapath.sv
module rfu_datapath (
   input  logic                  clock,
   input  rfu_pkg::req_word_type req_word,
   input  rfu_pkg::dp_cmd_type   cmd,
   output rfu_pkg::dp_status_type status,
   output rfu_pkg::rsp_word_type rsp_word
);
   import rfu_pkg::*;

   req_word_type             item_ff;
   smag_type                 an, ad, bn, bd;
   logic [OPERAND_WIDTH-1:0] mul_x, mul_y;
   logic [DW-1:0]            prod;
   logic [DW-1:0]            p1_ff, p2_ff, p3_ff;
   logic                     p1n, p2n;
   logic [DW-1:0]            sum_mag;
   logic                     sum_neg;
   logic [DW-1:0]            num_ff, den_ff;
   logic                     neg_ff;
   logic [DW-1:0]            ga_ff, gb_ff;
   logic [CW-1:0]            sh_ff;
   logic [DW-1:0]            divisor_ff, quo_ff;
   logic [DW:0]              rem_ff, rem_sh;
   logic [CW-1:0]            cnt_ff;
   logic [63:0]              qext;
   rsp_word_type             res_ff, rsp_ff;

   assign an = split_operand(item_ff.a_numerator);
   assign ad = split_operand(item_ff.a_denominator);
   assign bn = split_operand(item_ff.b_numerator);
   assign bd = split_operand(item_ff.b_denominator);
   assign p1n = an.neg ^ bd.neg;
   assign p2n = bn.neg ^ ad.neg;

   // shared multiplier, product registered into p1/p2/p3
   always_comb begin
      case (cmd)
         C_MUL1: begin mul_x = an.mag; mul_y = bd.mag; end
         C_MUL2: begin mul_x = bn.mag; mul_y = ad.mag; end
         default: begin mul_x = ad.mag; mul_y = bd.mag; end
      endcase
      prod = DW'(mul_x) * DW'(mul_y);
   end

   always_comb begin
      if (p1n == p2n) begin
         sum_mag = p1_ff + p2_ff;
         sum_neg = p1n;
      end else if (p1_ff >= p2_ff) begin
         sum_mag = p1_ff - p2_ff;
         sum_neg = p1n;
      end else begin
         sum_mag = p2_ff - p1_ff;
         sum_neg = p2n;
      end
   end

   assign rem_sh = {rem_ff[DW-1:0], quo_ff[DW-1]};
   assign qext = 64'(quo_ff);

   always_comb begin
      status.command = item_ff.command;
      case (item_ff.command)
         OP_NORMALIZE: status.zerr = (ad.mag == '0);
         OP_ADD, OP_COMPARE: status.zerr = (ad.mag == '0) || (bd.mag == '0);
         default: status.zerr = 1'b0;
      endcase
      status.num_zero  = (num_ff == '0);
      status.both_even = !ga_ff[0] && !gb_ff[0];
      status.a_even    = !ga_ff[0];
      status.b_zero    = (gb_ff == '0);
      status.div_last  = (cnt_ff == CW'(DW - 1));
   end

   always_ff @(posedge clock) begin
      case (cmd)
         C_LOAD: item_ff <= req_word;
         C_TRIV: begin
            res_ff.result_numerator   <= '0;
            res_ff.result_denominator <= 62'd1;
            res_ff.is_equal           <= 1'b0;
            res_ff.zero_denominator   <= status.zerr;
         end
         C_MUL1: p1_ff <= prod;
         C_MUL2: p2_ff <= prod;
         C_MUL3: p3_ff <= prod;
         C_SUM: begin
            num_ff <= sum_mag;
            den_ff <= p3_ff;
            neg_ff <= sum_neg ^ ad.neg ^ bd.neg;
         end
         C_CMP: begin
            res_ff.result_numerator   <= '0;
            res_ff.result_denominator <= 62'd1;
            res_ff.is_equal           <= (p1_ff == p2_ff) && ((p1_ff == '0) || (p1n == p2n));
            res_ff.zero_denominator   <= 1'b0;
         end
         C_NLOAD: begin
            num_ff <= DW'(an.mag);
            den_ff <= DW'(ad.mag);
            neg_ff <= an.neg ^ ad.neg;
         end
         C_GINIT: begin
            ga_ff <= num_ff;
            gb_ff <= den_ff;
            sh_ff <= '0;
         end
         C_GTWO: begin
            if (status.both_even) begin
               ga_ff <= ga_ff >> 1;
               gb_ff <= gb_ff >> 1;
               sh_ff <= sh_ff + 1'b1;
            end
         end
         C_GAEVEN: begin
            if (status.a_even) ga_ff <= ga_ff >> 1;
         end
         C_GSTEP: begin
            if (status.b_zero) begin
            end else if (!gb_ff[0]) begin
               gb_ff <= gb_ff >> 1;
            end else if (ga_ff > gb_ff) begin
               ga_ff <= gb_ff;
               gb_ff <= ga_ff - gb_ff;
            end else begin
               gb_ff <= gb_ff - ga_ff;
            end
         end
         C_DIVN_INIT: begin
            divisor_ff <= ga_ff << sh_ff;
            rem_ff     <= '0;
            quo_ff     <= num_ff;
            cnt_ff     <= '0;
         end
         C_DIV_STEP: begin
            if (rem_sh >= {1'b0, divisor_ff}) begin
               rem_ff <= rem_sh - {1'b0, divisor_ff};
               quo_ff <= {quo_ff[DW-2:0], 1'b1};
            end else begin
               rem_ff <= rem_sh;
               quo_ff <= {quo_ff[DW-2:0], 1'b0};
            end
            cnt_ff <= cnt_ff + 1'b1;
         end
         C_DIVD_INIT: begin
            res_ff.result_numerator <= neg_ff ? (64'd0 - qext) : qext;
            res_ff.is_equal         <= 1'b0;
            res_ff.zero_denominator <= 1'b0;
            rem_ff <= '0;
            quo_ff <= den_ff;
            cnt_ff <= '0;
         end
         C_DIVD_DONE: res_ff.result_denominator <= 62'(quo_ff);
         C_OUT: rsp_ff <= res_ff;
         default: begin
         end
      endcase
   end

   assign rsp_word = rsp_ff;

endmodule

FILE: sv/rfu_controller.sv
module rfu_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  rfu_pkg::dp_status_type status,
   output rfu_pkg::dp_cmd_type    cmd
);
   import rfu_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:   if (req_valid) state_in = S_CHECK;
         S_CHECK: begin
            if (status.zerr || status.command == OP_UNUSED) state_in = S_TRIV;
            else if (status.command == OP_NORMALIZE) state_in = S_NLOAD;
            else state_in = S_MUL1;
         end
         S_MUL1:   state_in = S_MUL2;
         S_MUL2:   state_in = (status.command == OP_COMPARE) ? S_CMP : S_MUL3;
         S_MUL3:   state_in = S_SUM;
         S_SUM:    state_in = S_ZTEST;
         S_NLOAD:  state_in = S_ZTEST;
         S_ZTEST:  state_in = status.num_zero ? S_TRIV : S_GINIT;
         S_CMP:    state_in = S_FINISH;
         S_TRIV:   state_in = S_FINISH;
         S_GINIT:  state_in = S_GTWO;
         S_GTWO:   if (!status.both_even) state_in = S_GAEVEN;
         S_GAEVEN: if (!status.a_even) state_in = S_GLOOP;
         S_GLOOP:  if (status.b_zero) state_in = S_DIVN_INIT;
         S_DIVN_INIT: state_in = S_DIVN;
         S_DIVN:   if (status.div_last) state_in = S_DIVD_INIT;
         S_DIVD_INIT: state_in = S_DIVD;
         S_DIVD:   if (status.div_last) state_in = S_DIVD_DONE;
         S_DIVD_DONE: state_in = S_FINISH;
         S_FINISH: if (out_free) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd = C_NONE;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         S_IDLE:      if (req_valid) cmd = C_LOAD;
         S_MUL1:      cmd = C_MUL1;
         S_MUL2:      cmd = C_MUL2;
         S_MUL3:      cmd = C_MUL3;
         S_SUM:       cmd = C_SUM;
         S_NLOAD:     cmd = C_NLOAD;
         S_CMP:       cmd = C_CMP;
         S_TRIV:      cmd = C_TRIV;
         S_GINIT:     cmd = C_GINIT;
         S_GTWO:      cmd = C_GTWO;
         S_GAEVEN:    cmd = C_GAEVEN;
         S_GLOOP:     cmd = C_GSTEP;
         S_DIVN_INIT: cmd = C_DIVN_INIT;
         S_DIVN:      cmd = C_DIV_STEP;
         S_DIVD_INIT: cmd = C_DIVD_INIT;
         S_DIVD:      cmd = C_DIV_STEP;
         S_DIVD_DONE: cmd = C_DIVD_DONE;
         S_FINISH: begin
            if (out_free) begin
               cmd = C_OUT;
               rsp_valid_in = 1'b1;
            end
         end
         default: cmd = C_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_accept_to_check: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> state_ff == S_CHECK)
      else $error("accepted word did not advance to check");

   a_finish_loads_out: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH && out_free) |=> rsp_valid)
      else $error("finished result not presented");

   a_finish_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH && rsp_valid_ff && rsp_stall) |=> state_ff == S_FINISH)
      else $error("pending result overwritten");

   a_gcd_a_odd: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_GLOOP) |-> !status.a_even)
      else $error("gcd operand a lost odd form");

endmodule

FILE: sv/rational_fraction_unit.sv
// Rational fraction unit: exact normalize, add and compare of signed fractions.
// Request channel (req_valid / req_stall / req_word) carries a command and two
// fractions A and B; a word is taken when req_valid is high and req_stall low.
// Response channel (rsp_valid / rsp_stall / rsp_word) returns one word per
// request: reduced numerator, positive denominator, equal and zero-denominator
// flags. Zero denominators and the unused command give 0/1 at once.
// One request is worked at a time; req_stall is high from acceptance until the
// result moves to the output register. Steps after acceptance:
//   zero-denominator and unused-command items: straight to 0/1; compare: two
//   products, then the compare; a zero numerator: 0/1 after the load or sum;
//   other normalize / add: the load or three products and a sum, a binary gcd
//   of one shift or subtract per cycle, then two restoring divisions of DW
//   quotient bits each.
// The shared 32x32 multiplier takes one product per cycle (three for add).
// The output register parts the sides: a new request is taken while a finished
// word waits under rsp_stall; the next result then holds until the word drains.
// Reset (synchronous, active high) drops any item in flight and clears
// rsp_valid; no clearing pass is needed.
module rational_fraction_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  rfu_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rfu_pkg::rsp_word_type rsp_word
);
   import rfu_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   // sequencer: walks multiply, gcd and divide steps
   rfu_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: operand registers, multiplier, gcd and divider, output word
   rfu_datapath u_dp (
      .clock    (clock),
      .req_word (req_word),
      .cmd      (cmd),
      .status   (status),
      .rsp_word (rsp_word)
   );

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import rfu_pkg::*;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   req_word_type req_word;
   logic         rsp_valid;
   logic         rsp_stall;
   rsp_word_type rsp_word;

   // idle odds in percent for the sender and the receiver
   int unsigned  send_idle_pct;
   int unsigned  recv_stall_pct;

   rsp_word_type expected_words[$];
   int unsigned  mismatch_count;
   int unsigned  orphan_count;

   rational_fraction_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   // Split a 32-bit two's complement operand into sign and magnitude.
   function automatic void operand_parts(input logic [31:0] v, output bit neg,
                                         output logic [63:0] mag);
      neg = v[31];
      mag = {32'd0, (v[31] ? (~v + 32'd1) : v)};
   endfunction

   function automatic logic [63:0] binary_gcd(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] t;
      int          sh;
      sh = 0;
      if (a == 0) return b;
      if (b == 0) return a;
      while (((a | b) & 64'd1) == 0) begin
         a = a >> 1;
         b = b >> 1;
         sh++;
      end
      while (a[0] == 1'b0) a = a >> 1;
      while (b != 0) begin
         while (b[0] == 1'b0) b = b >> 1;
         if (a > b) begin
            t = a;
            a = b;
            b = t;
         end
         b = b - a;
      end
      return a << sh;
   endfunction

   // Reduce n/d (d nonzero) to lowest terms with a positive denominator.
   function automatic void lowest_terms(input bit nneg, input logic [63:0] nmag,
                                        input bit dneg, input logic [63:0] dmag,
                                        output bit rneg, output logic [63:0] rmag,
                                        output logic [63:0] rden);
      logic [63:0] g;
      g = binary_gcd(nmag, dmag);
      if (g == 0) g = 1;
      rmag = nmag / g;
      rneg = (rmag != 0) && (nneg != dneg);
      rden = dmag / g;
   endfunction

   function automatic rsp_word_type fraction_result(input req_word_type w);
      rsp_word_type r;
      bit           an_s, ad_s, bn_s, bd_s, p1_s, p2_s, s_s, rn_s, x_s, y_s;
      logic [63:0]  an, ad, bn, bd, p1, p2, s, rn, rd, x, xd, y, yd;
      operand_parts(w.a_numerator, an_s, an);
      operand_parts(w.a_denominator, ad_s, ad);
      operand_parts(w.b_numerator, bn_s, bn);
      operand_parts(w.b_denominator, bd_s, bd);
      rn_s = 0;
      rn = 0;
      rd = 1;
      r = '0;
      case (op_type'(w.command))
         OP_NORMALIZE: begin
            if (ad == 0) r.zero_denominator = 1'b1;
            else lowest_terms(an_s, an, ad_s, ad, rn_s, rn, rd);
         end
         OP_ADD: begin
            if (ad == 0 || bd == 0) begin
               r.zero_denominator = 1'b1;
            end else begin
               p1_s = an_s ^ bd_s;
               p1 = an * bd;
               p2_s = bn_s ^ ad_s;
               p2 = bn * ad;
               if (p1_s == p2_s) begin
                  s_s = p1_s;
                  s = p1 + p2;
               end else if (p1 >= p2) begin
                  s_s = p1_s;
                  s = p1 - p2;
               end else begin
                  s_s = p2_s;
                  s = p2 - p1;
               end
               lowest_terms(s_s, s, ad_s ^ bd_s, ad * bd, rn_s, rn, rd);
            end
         end
         OP_COMPARE: begin
            if (ad == 0 || bd == 0) begin
               r.zero_denominator = 1'b1;
            end else begin
               lowest_terms(an_s, an, ad_s, ad, x_s, x, xd);
               lowest_terms(bn_s, bn, bd_s, bd, y_s, y, yd);
               r.is_equal = (x_s == y_s) && (x == y) && (xd == yd);
            end
         end
         default: ;
      endcase
      r.result_numerator = rn_s ? (64'd0 - rn) : rn;
      r.result_denominator = rd[61:0];
      return r;
   endfunction

   // Hold the word until taken; drop valid only for the sender gaps drawn
   // before each word.
   task automatic send_fraction(input req_word_type w);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word <= w;
      expected_words.push_back(fraction_result(w));
      do @(posedge clock); while (req_stall);
   endtask

   function automatic logic [31:0] random_operand();
      case ($urandom_range(5))
         0: return $urandom_range(20);
         1: return -$urandom_range(20);
         2: return {1'($urandom_range(1)), 31'd0} | $urandom_range(3);
         3: return $urandom_range(1) ? 32'h7fffffff : 32'h80000001;
         default: return $urandom;
      endcase
   endfunction

   function automatic req_word_type random_word();
      req_word_type w;
      int unsigned  pick;
      logic [31:0]  k;
      pick = $urandom_range(99);
      w.command = (pick < 3) ? OP_UNUSED : op_type'($urandom_range(2));
      w.a_numerator = random_operand();
      w.a_denominator = random_operand();
      w.b_numerator = random_operand();
      w.b_denominator = random_operand();
      // scaled copies of A make compare hits common
      if (w.command == OP_COMPARE && $urandom_range(1)) begin
         k = $urandom_range(1, 7);
         w.a_numerator = $signed(w.a_numerator) / 8;
         w.a_denominator = ($signed(w.a_denominator) / 8) | 32'd1;
         w.b_numerator = w.a_numerator * ($urandom_range(1) ? k : -k);
         w.b_denominator = w.b_numerator[31] == w.a_numerator[31] ?
                           w.a_denominator * k : -(w.a_denominator * k);
      end
      return w;
   endfunction

   task automatic send_parts(input op_type op, input logic [31:0] an, input logic [31:0] ad,
                             input logic [31:0] bn, input logic [31:0] bd);
      req_word_type w;
      w.command = op;
      w.a_numerator = an;
      w.a_denominator = ad;
      w.b_numerator = bn;
      w.b_denominator = bd;
      send_fraction(w);
   endtask

   task automatic test_directed();
      send_parts(OP_NORMALIZE, 6, -4, 0, 0);
      send_parts(OP_NORMALIZE, 0, -7, 1, 1);
      send_parts(OP_NORMALIZE, 5, 0, 3, 3);
      send_parts(OP_NORMALIZE, 32'h80000000, 32'h80000000, 0, 1);
      send_parts(OP_NORMALIZE, 32'h7fffffff, 32'h80000000, 0, 1);
      send_parts(OP_NORMALIZE, 32'hffffffff, 32'h7fffffff, 0, 1);
      send_parts(OP_ADD, 1, 2, 1, 3);
      send_parts(OP_ADD, 1, 2, -1, 2);
      send_parts(OP_ADD, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
      send_parts(OP_ADD, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h80000001);
      send_parts(OP_ADD, 1, 0, 1, 1);
      send_parts(OP_ADD, 1, 1, 1, 0);
      send_parts(OP_COMPARE, 2, 4, -1, -2);
      send_parts(OP_COMPARE, 2, 4, 1, -2);
      send_parts(OP_COMPARE, 0, 5, 0, -3);
      send_parts(OP_COMPARE, 1, 1, 1, 0);
      send_parts(OP_COMPARE, 32'h80000000, 32'h80000000, 1, 1);
      send_parts(OP_UNUSED, 3, 4, 5, 6);
      send_parts(OP_UNUSED, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
   endtask

   task automatic test_random(input int unsigned count, input int unsigned idle_pct,
                              input int unsigned stall_pct);
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      repeat (count) send_fraction(random_word());
   endtask

   // Draw the receiver stall each cycle.
   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // Compare each taken result word with the oldest prediction.
   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_words.size() == 0) begin
            orphan_count++;
            if (mismatch_count + orphan_count <= 10)
               $display("unexpected result word %h", rsp_word);
         end else begin
            want = expected_words.pop_front();
            if (rsp_word !== want) begin
               mismatch_count++;
               if (mismatch_count + orphan_count <= 10)
                  $display("mismatch: want %0d/%0d eq %b zd %b, got %0d/%0d eq %b zd %b",
                     want.result_numerator, want.result_denominator, want.is_equal,
                     want.zero_denominator, rsp_word.result_numerator,
                     rsp_word.result_denominator, rsp_word.is_equal, rsp_word.zero_denominator);
            end
         end
      end
   end

   initial begin
      #10000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_word = '0;
      rsp_stall = 1'b0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      mismatch_count = 0;
      orphan_count = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(330, 0, 0);
      test_random(330, 49, 0);
      test_random(330, 0, 49);
      test_random(330, 16, 16);
      req_valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (mismatch_count == 0 && orphan_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule

FILE: files.f
sv/rfu_pkg.sv
sv/rfu_datapath.sv
sv/rfu_controller.sv
sv/rational_fraction_unit.sv
sim/testbench.sv
